@@ hw/rtl/bdlc_pkg.sv @@
// shared types and constants for the button debounce and press counter
package bdlc_pkg;

  localparam int NUM_BUTTONS  = 20;
  localparam int IDX_W        = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int LEVELS_W     = 20;
  localparam int ID_W         = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [7:0] DEBOUNCE_MAX = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;

  localparam logic [15:0] SCAN_PERIOD_RESET = 16'd5;
  localparam logic [15:0] LOCKOUT_RESET     = 16'd2500;
  localparam logic [7:0]  THRESHOLD_RESET   = 8'd2;

  // request and result codes
  localparam logic ACTION_SCAN = 1'b0;
  localparam logic ACTION_READ = 1'b1;
  localparam logic KIND_EVENT  = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic                action;
    logic [31:0]         now_ms;
    logic [LEVELS_W-1:0] levels;
    logic [ID_W-1:0]     button_index;
  } bdlc_in_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] button_id;
    logic [31:0]     press_count;
    logic            last;
  } bdlc_out_t;

  // one per-button memory word
  typedef struct packed {
    logic [31:0] presses;
    logic [31:0] start;
    logic        active;
    logic [7:0]  count;
  } bdlc_entry_t;

endpackage

@@ hw/rtl/bdlc_ram.sv @@
// per-button state memory, one write port and one registered read port
module bdlc_ram
  import bdlc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  bdlc_entry_t       wdata,
  input  logic [IDX_W-1:0]  raddr,
  output bdlc_entry_t       rdata
);

  bdlc_entry_t mem [NUM_BUTTONS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/button_debounce_lockout_counter_top.sv @@
// top level of the button debounce, lockout and press counter
//
// A scan request (action 0) is acted on only when now_ms minus the last
// acted-on scan time exceeds scan_period_ms. It then walks the per-button
// memory one entry per cycle unless stalled, updating the debounce count,
// starting and completing lockouts, and emitting one event per completed
// lockout in ascending button order, the final one flagged last. A read
// request (action 1) returns one button's press count. An acted-on scan
// walks the entries one at a time, as set by the single read and write port
// of the state memory, then hands the final result to the output register
// before the next request can be taken. A dropped scan leaves the block
// idle; a read passes through a response step and the final hand-off. The
// walk stalls whenever a new event finds one already parked and the output
// register not taken, and the final hand-off waits for the output register
// to be free. A new request is taken only once the previous one is finished.
// Per-entry valid bits, cleared by reset, make unwritten entries read as
// zero but for the start time, unused until a lockout sets it, so no
// clearing pass is needed. Configuration is written through cfg_we /
// cfg_index / cfg_data while the block is idle, which the user must ensure.
module button_debounce_lockout_counter_top
  import bdlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bdlc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bdlc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {IDLE, SCAN, RESP, FLUSH} state_t;

  state_t state;

  // configuration registers
  logic [15:0] scan_period_ms;
  logic [15:0] lockout_ms;
  logic [7:0]  press_threshold;

  // scan context
  logic [31:0]            last_scan_time;
  logic [31:0]            scan_now;
  logic [NUM_BUTTONS-1:0] scan_levels;
  logic [IDX_W-1:0]       idx;
  logic [ID_W-1:0]        read_id;
  logic                   read_ok;
  logic [NUM_BUTTONS-1:0] entry_valid;

  // one event held back until we know whether another follows
  logic      pend_v;
  bdlc_out_t pend;

  // memory interface
  logic         mem_we;
  logic [IDX_W-1:0] mem_raddr;
  bdlc_entry_t  mem_rdata;
  bdlc_entry_t  cur;
  bdlc_entry_t  upd;

  logic        in_accept;
  logic        out_free;
  logic        scan_due;
  logic        emit;
  logic        hold;
  logic        idx_last;
  logic [7:0]  cnt_new;
  logic        rd_in_range;
  logic [31:0] elapsed;
  logic        out_load;
  logic        out_last;

  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign scan_due  = (in_data.now_ms - last_scan_time) > {16'd0, scan_period_ms};
  assign idx_last  = (idx == IDX_W'(NUM_BUTTONS - 1));
  assign rd_in_range = ({1'b0, in_data.button_index} < (ID_W + 1)'(NUM_BUTTONS));

  // entry on the read port, zero but for start where never written
  always_comb begin
    cur = entry_valid[idx] ? mem_rdata : '0;
    if (!entry_valid[idx]) begin
      cur.start = mem_rdata.start;
    end
  end

  // per-button update: debounce, lockout start, lockout completion
  always_comb begin
    upd = cur;
    if (!scan_levels[idx]) begin
      cnt_new = 8'd0;
    end else if (cur.count == DEBOUNCE_MAX) begin
      cnt_new = DEBOUNCE_MAX;
    end else begin
      cnt_new = cur.count + 8'd1;
    end
    upd.count = cnt_new;
    elapsed   = scan_now - cur.start;
    emit      = 1'b0;
    if (cur.active) begin
      // a lockout started in this scan cannot complete in it
      if (elapsed > {16'd0, lockout_ms}) begin
        emit        = 1'b1;
        upd.active  = 1'b0;
        upd.presses = cur.presses + 32'd1;
      end
    end else if (cnt_new > press_threshold) begin
      upd.active = 1'b1;
      upd.start  = scan_now;
    end
  end

  // a second event cannot be parked while the output register is full
  assign hold   = (state == SCAN) && emit && pend_v && !out_free;
  assign mem_we = (state == SCAN) && !hold;

  // the parked event moves out when a newer one replaces it (not the final
  // one) or at the end of the request (the final one)
  assign out_load = ((state == SCAN) && !hold && emit && pend_v) ||
                    ((state == FLUSH) && pend_v && out_free);
  assign out_last = (state == FLUSH);

  always_comb begin
    case (state)
      IDLE: begin
        if (in_data.action == ACTION_READ && rd_in_range) begin
          mem_raddr = in_data.button_index[IDX_W-1:0];
        end else begin
          mem_raddr = '0;
        end
      end
      SCAN: begin
        if (hold || idx_last) begin
          mem_raddr = idx;
        end else begin
          mem_raddr = idx + 1'b1;
        end
      end
      default: mem_raddr = idx;
    endcase
  end

  bdlc_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (upd),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period_ms  <= SCAN_PERIOD_RESET;
      lockout_ms      <= LOCKOUT_RESET;
      press_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_PERIOD: scan_period_ms  <= cfg_data;
        REG_LOCKOUT:     lockout_ms      <= cfg_data;
        REG_THRESHOLD:   press_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{pend.kind, pend.button_id, pend.press_count, out_last};
    end
  end

  // sequencer and event buffering
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      last_scan_time <= '0;
      entry_valid    <= '0;
      pend_v         <= 1'b0;
      idx            <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_accept) begin
            if (in_data.action == ACTION_READ) begin
              read_id <= in_data.button_index;
              read_ok <= rd_in_range;
              idx     <= rd_in_range ? in_data.button_index[IDX_W-1:0] : '0;
              state   <= RESP;
            end else if (scan_due) begin
              last_scan_time <= in_data.now_ms;
              scan_now       <= in_data.now_ms;
              scan_levels    <= NUM_BUTTONS'(in_data.levels);
              idx            <= '0;
              state          <= SCAN;
            end
          end
        end
        SCAN: begin
          if (!hold) begin
            entry_valid[idx] <= 1'b1;
            if (emit) begin
              pend_v <= 1'b1;
              pend   <= '{KIND_EVENT, ID_W'(idx), upd.presses, 1'b0};
            end
            if (idx_last) begin
              state <= FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        RESP: begin
          pend_v <= 1'b1;
          pend   <= '{KIND_READ, read_id,
                      (read_ok && entry_valid[idx]) ? mem_rdata.presses : 32'd0, 1'b0};
          state  <= FLUSH;
        end
        FLUSH: begin
          if (!pend_v) begin
            state <= IDLE;
          end else if (out_free) begin
            pend_v <= 1'b0;
            state  <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ sim/button_debounce_lockout_counter_top_test.sv @@
// testbench for the button debounce, lockout and press counter
module button_debounce_lockout_counter_top_test;
  import bdlc_pkg::*;

  // cycles to wait after the last result before touching config or ending,
  // enough to cover the walk of a scan that emits nothing
  localparam int SETTLE_CYCLES  = 32;
  // long receiver hold-off so the block fills up and stalls requests
  localparam int HOLDOFF_CYCLES = 400;
  // generous ceiling, far above the slowest legal run
  localparam int TIMEOUT        = 4000000;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,  // compare against the predictor
    CHK_NONE,     // no result may come
    CHK_COUNT     // one read response with the typed-in count
  } row_check_e;

  typedef struct packed {
    bdlc_in_t    req;
    row_check_e  check;
    logic [31:0] count;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 21;

  // reset config: scan period 5, lockout 2500, threshold 2
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // reads after reset, in range, at the top of range and out of range
    '{'{ACTION_READ, 32'd0,          20'h00000, 5'd0},  CHK_COUNT,   32'd0},
    '{'{ACTION_READ, 32'd0,          20'h00000, 5'd19}, CHK_COUNT,   32'd0},
    '{'{ACTION_READ, 32'hFFFF_FFFF,  20'hFFFFF, 5'd31}, CHK_COUNT,   32'd0},
    '{'{ACTION_READ, 32'd0,          20'h00000, 5'd20}, CHK_COUNT,   32'd0},
    // elapsed equal to the period is too early
    '{'{ACTION_SCAN, 32'd5,          20'hFFFFF, 5'd31}, CHK_NONE,    32'd0},
    '{'{ACTION_SCAN, 32'd6,          20'hFFFFF, 5'd0},  CHK_NONE,    32'd0},
    '{'{ACTION_SCAN, 32'd11,         20'hFFFFF, 5'd0},  CHK_NONE,    32'd0},
    '{'{ACTION_SCAN, 32'd12,         20'hFFFFF, 5'd0},  CHK_NONE,    32'd0},
    // third high scan beats the threshold, every lockout starts at 18
    '{'{ACTION_SCAN, 32'd18,         20'hFFFFF, 5'd0},  CHK_NONE,    32'd0},
    // exactly lockout_ms after the start does not complete yet
    '{'{ACTION_SCAN, 32'd2518,       20'hFFFFF, 5'd0},  CHK_NONE,    32'd0},
    // all twenty lockouts complete in one scan
    '{'{ACTION_SCAN, 32'd2524,       20'hFFFFF, 5'd0},  CHK_PREDICT, 32'd0},
    '{'{ACTION_READ, 32'd0,          20'h00000, 5'd7},  CHK_COUNT,   32'd1},
    '{'{ACTION_SCAN, 32'd2530,       20'h00000, 5'd0},  CHK_NONE,    32'd0},
    // time wraps through zero between scans, just before a lockout starts
    '{'{ACTION_SCAN, 32'hFFFF_FFF0,  20'hAAAAA, 5'd0},  CHK_NONE,    32'd0},
    '{'{ACTION_SCAN, 32'hFFFF_FFF8,  20'hAAAAA, 5'd0},  CHK_NONE,    32'd0},
    '{'{ACTION_SCAN, 32'd2,          20'hAAAAA, 5'd0},  CHK_NONE,    32'd0},
    '{'{ACTION_SCAN, 32'd2502,       20'hAAAAA, 5'd0},  CHK_NONE,    32'd0},
    // released buttons still finish their lockout
    '{'{ACTION_SCAN, 32'd2508,       20'h00000, 5'd0},  CHK_PREDICT, 32'd0},
    '{'{ACTION_READ, 32'd0,          20'h00000, 5'd1},  CHK_COUNT,   32'd2},
    '{'{ACTION_READ, 32'd0,          20'h00000, 5'd0},  CHK_COUNT,   32'd1},
    '{'{ACTION_SCAN, 32'd2511,       20'hFFFFF, 5'd0},  CHK_NONE,    32'd0}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  bdlc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  bdlc_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SCAN_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor copy of the per-button state and the registers
  logic [7:0]  held_scans  [NUM_BUTTONS];
  logic        locked      [NUM_BUTTONS];
  logic [31:0] lock_time   [NUM_BUTTONS];
  logic [31:0] press_total [NUM_BUTTONS];
  logic [31:0] prev_scan_ms;
  logic [15:0] cfg_period;
  logic [15:0] cfg_lockout;
  logic [7:0]  cfg_threshold;

  bdlc_out_t predicted [$];         // results of the request just accepted
  bdlc_out_t expected_results [$];  // results still owed by the block

  logic [31:0]         sim_ms     = 32'd2511;  // time base for random scans
  logic [LEVELS_W-1:0] key_levels = '0;        // button levels carried between scans
  logic                calm_mode  = 1'b0;      // no idling on either side
  logic                holdoff_request = 1'b0;
  int                  failures   = 0;

  button_debounce_lockout_counter_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // run-away guard
  initial begin
    #TIMEOUT;
    $display("status: fail");
    $finish;
  end

  task automatic reset_predictor();
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      held_scans[i]  = '0;
      locked[i]      = 1'b0;
      lock_time[i]   = '0;
      press_total[i] = '0;
    end
    prev_scan_ms  = '0;
    cfg_period    = SCAN_PERIOD_RESET;
    cfg_lockout   = LOCKOUT_RESET;
    cfg_threshold = THRESHOLD_RESET;
  endtask

  // works out what one request produces and advances the predictor state
  task automatic predict_request(input bdlc_in_t req);
    bdlc_out_t   ev;
    logic [31:0] elapsed;
    predicted.delete();
    if (req.action == ACTION_READ) begin
      ev.kind        = KIND_READ;
      ev.button_id   = req.button_index;
      ev.press_count = (req.button_index < NUM_BUTTONS) ? press_total[req.button_index] : '0;
      ev.last        = 1'b1;
      predicted.push_back(ev);
      return;
    end
    // wrap-safe check against the last acted-on scan
    elapsed = req.now_ms - prev_scan_ms;
    if (elapsed <= {16'd0, cfg_period}) return;
    prev_scan_ms = req.now_ms;
    // debounce counts, saturating while held
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (!req.levels[i]) held_scans[i] = '0;
      else if (held_scans[i] != DEBOUNCE_MAX) held_scans[i] = held_scans[i] + 8'd1;
    end
    // qualified presses start a lockout
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (held_scans[i] > cfg_threshold && !locked[i]) begin
        locked[i]    = 1'b1;
        lock_time[i] = req.now_ms;
      end
    end
    // expired lockouts count and emit, lowest button first
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      elapsed = req.now_ms - lock_time[i];
      if (locked[i] && elapsed > {16'd0, cfg_lockout}) begin
        press_total[i] = press_total[i] + 32'd1;
        locked[i]      = 1'b0;
        ev.kind        = KIND_EVENT;
        ev.button_id   = ID_W'(i);
        ev.press_count = press_total[i];
        ev.last        = 1'b0;
        predicted.push_back(ev);
      end
    end
    if (predicted.size() != 0) predicted[predicted.size()-1].last = 1'b1;
  endtask

  // sender idles now and then, never while in calm mode
  task automatic gap();
    if (!calm_mode && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // holds the request until the block takes it, then books its results
  task automatic offer(input bdlc_in_t req, input row_check_e check, input logic [31:0] count);
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_request(req);
    case (check)
      CHK_PREDICT: begin
        foreach (predicted[k]) expected_results.push_back(predicted[k]);
      end
      CHK_COUNT: begin
        expected_results.push_back('{KIND_READ, req.button_index, count, 1'b1});
      end
      default: ;
    endcase
  endtask

  // wait for the block to drain and go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // writes all three registers while idle; only the low byte sets the threshold
  task automatic configure(input logic [15:0] period, input logic [15:0] lockout,
                           input logic [15:0] threshold_word);
    settle();
    put_reg(REG_SCAN_PERIOD, period);
    put_reg(REG_LOCKOUT, lockout);
    put_reg(REG_THRESHOLD, threshold_word);
    cfg_we        <= 1'b0;
    cfg_period    = period;
    cfg_lockout   = lockout;
    cfg_threshold = threshold_word[7:0];
  endtask

  // random requests: mostly scans whose levels drift so buttons get held and
  // released over several scans, some fully random scans, some reads
  task automatic run_phase(input int items, input int step_lo, input int step_hi,
                           input logic [LEVELS_W-1:0] held, input int read_pct);
    bdlc_in_t req;
    for (int n = 0; n < items; n++) begin
      req.now_ms       = $urandom;
      req.levels       = LEVELS_W'($urandom);
      req.button_index = ID_W'($urandom);
      if ($urandom_range(99) < read_pct) begin
        req.action = ACTION_READ;
        // mostly real buttons, some indexes past the end
        if ($urandom_range(9) != 0) req.button_index = ID_W'($urandom_range(0, NUM_BUTTONS-1));
      end else begin
        req.action = ACTION_SCAN;
        sim_ms     = sim_ms + 32'($urandom_range(step_lo, step_hi));
        req.now_ms = sim_ms;
        if ($urandom_range(9) != 0) begin
          key_levels = key_levels ^ LEVELS_W'($urandom & $urandom & $urandom);
          req.levels = key_levels | held;
        end
      end
      gap();
      offer(req, CHK_PREDICT, '0);
    end
  endtask

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      out_stall <= !calm_mode && ($urandom_range(99) < 31);
    end
  end

  // every accepted result is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    bdlc_out_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d button_id %0d press_count %0d last %0d",
               out_data.kind, out_data.button_id, out_data.press_count, out_data.last);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          failures++;
        end
        if (out_data.button_id !== want.button_id) begin
          $error("button_id: expected %0d, got %0d", want.button_id, out_data.button_id);
          failures++;
        end
        if (out_data.press_count !== want.press_count) begin
          $error("press_count: expected %0d, got %0d", want.press_count, out_data.press_count);
          failures++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          failures++;
        end
      end
    end
  end

  // request side
  initial begin : stimulus
    logic [LEVELS_W-1:0] held;
    reset_predictor();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows at reset config
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      gap();
      offer(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].check, DIRECTED_ROWS[r].count);
    end

    // all registers at zero: scans every ms, lockouts finish on the next scan;
    // the receiver holds off meanwhile so the block backs up
    configure(16'd0, 16'd0, 16'd0);
    holdoff_request = 1'b1;
    run_phase(80, 0, 3, '0, 15);

    // period and lockout at the top, big time steps that wrap the clock;
    // threshold word has upper bits set that must be dropped
    sim_ms = 32'hFFF0_0000 | 32'($urandom_range(0, 65535));
    configure(16'hFFFF, 16'hFFFF, 16'h0101);
    run_phase(50, 0, 200000, '0, 15);

    // a few buttons held throughout so their counts saturate, highest
    // usable threshold so only a saturated count qualifies
    held = '0;
    repeat (3) held[$urandom_range(0, NUM_BUTTONS-1)] = 1'b1;
    configure(16'd3, 16'd40, 16'd254);
    calm_mode = 1'b1;
    run_phase(60, 4, 6, held, 8);
    calm_mode = 1'b0;
    run_phase(230, 3, 12, held, 8);

    // threshold no count can pass, leftover lockouts still finish
    configure(16'd5, 16'd10, 16'd255);
    run_phase(40, 4, 10, held, 15);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
